// ===== src/ptpaq_pkg.sv =====
package ptpaq_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned TARGET_W  = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned RANK_W    = 8;

  // operation codes on the func field; code 3 means nothing
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ      = 2'd0,
    FUNC_CANCEL   = 2'd1,
    FUNC_DISPATCH = 2'd2
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISPATCH
  } state_e;

  // one queued action
  typedef struct packed {
    logic [TARGET_W-1:0]  target;
    logic [PAYLOAD_W-1:0] payload;
    logic [RANK_W-1:0]    rank;
  } entry_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic   valid;
    logic   dead;
    entry_t entry;
  } cell_link_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                enq;
    logic                cancel;
    logic                pop;
    entry_t              data;
    logic [TARGET_W-1:0] head_target;
    logic [RANK_W-1:0]   head_rank;
  } cell_ctrl_t;

  localparam cell_link_t LINK_FULL  = '{valid: 1'b1, dead: 1'b0, entry: '0};
  localparam cell_link_t LINK_EMPTY = '{valid: 1'b0, dead: 1'b0, entry: '0};

endpackage

// ===== src/ptpaq_in_if.sv =====
interface ptpaq_in_if import ptpaq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [TARGET_W-1:0]  target;
  logic [PAYLOAD_W-1:0] payload;
  logic [RANK_W-1:0]    rank;

  modport source (output valid, func, target, payload, rank, input ready);
  modport sink   (input valid, func, target, payload, rank, output ready);
endinterface

// ===== src/ptpaq_out_if.sv =====
interface ptpaq_out_if import ptpaq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TARGET_W-1:0]  winner_target;
  logic [PAYLOAD_W-1:0] winner_payload;
  logic                 last_of_run;

  modport source (output valid, winner_target, winner_payload, last_of_run, input ready);
  modport sink   (input valid, winner_target, winner_payload, last_of_run, output ready);
endinterface

// ===== src/ptpaq_cell.sv =====
module ptpaq_cell import ptpaq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  input  logic       right_kill_i,
  output cell_link_t link_o,
  output logic       kill_o,
  output logic       beat_o
);

  logic   valid_q, valid_d;
  logic   dead_q, dead_d;
  entry_t entry_q, entry_d;
  logic   same_tgt;

  // compare against the head entry during a dispatch
  assign same_tgt = (entry_q.target == ctrl_i.head_target);
  assign kill_o   = valid_q && same_tgt && (entry_q.rank >= ctrl_i.head_rank);
  assign beat_o   = valid_q && same_tgt && (entry_q.rank < ctrl_i.head_rank);

  assign link_o = '{valid: valid_q, dead: dead_q, entry: entry_q};

  // next cell contents
  always_comb begin
    valid_d = valid_q;
    dead_d  = dead_q;
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      // whole row shifts one cell toward the head
      valid_d = right_i.valid;
      dead_d  = right_i.dead | right_kill_i;
      entry_d = right_i.entry;
    end else if (ctrl_i.enq) begin
      // first empty cell takes the new entry
      if (!valid_q && left_i.valid) begin
        valid_d = 1'b1;
        dead_d  = 1'b0;
        entry_d = ctrl_i.data;
      end
    end else if (ctrl_i.cancel) begin
      if (valid_q && (entry_q.target == ctrl_i.data.target)) begin
        valid_d = 1'b0;
      end
    end else begin
      // compaction: holes bubble toward the tail
      if (!valid_q && right_i.valid) begin
        valid_d = 1'b1;
        dead_d  = right_i.dead;
        entry_d = right_i.entry;
      end else if (valid_q && !left_i.valid) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dead_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dead_q  <= dead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== src/per_target_priority_action_queue.sv =====
// channel  | port  | direction | payload
// request  | req_i | in        | func, target, payload, rank
// result   | rsp_o | out       | winner_target, winner_payload, last_of_run
//
// Enqueue and cancel act on the cells as soon as they are taken. After a cancel the row
// of cells closes its holes one step a cycle; new items wait until it is packed again.
// Dispatch pops one entry per cycle from the head cell, except while a new winner finds
// the output register still full, then sends the final result once the row is drained.
// Reset clears the occupancy of every cell and the controller; entry data is not reset.
// A finished result sits in an output register, so new items are taken while it waits.
module per_target_priority_action_queue import ptpaq_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TARGET_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptpaq_in_if.sink          req_i,
  ptpaq_out_if.source       rsp_o
);

  cell_link_t                links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    kill_vec;
  logic [QUEUE_DEPTH-1:0]    beat_vec;
  logic [QUEUE_DEPTH-1:0]    valid_vec;
  cell_ctrl_t                ctrl;

  state_e                    state_q, state_d;
  logic                      pend_q, pend_d;
  logic [TARGET_W-1:0]       pend_target_q, pend_target_d;
  logic [PAYLOAD_W-1:0]      pend_payload_q, pend_payload_d;
  logic                      out_valid_q, out_valid_d;
  logic [TARGET_W-1:0]       out_target_q, out_target_d;
  logic [PAYLOAD_W-1:0]      out_payload_q, out_payload_d;
  logic                      out_last_q, out_last_d;

  logic                      holes;
  logic                      full;
  logic                      tgt_ok;
  logic                      accept;
  logic                      beaten;
  logic                      head_win;
  logic                      out_free;

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;
    logic       right_kill;

    if (i == 0) begin : g_first
      assign left_link = LINK_FULL;
    end else begin : g_mid
      assign left_link = links[i-1];
    end
    if (i == QUEUE_DEPTH-1) begin : g_last
      assign right_link = LINK_EMPTY;
      assign right_kill = 1'b0;
    end else begin : g_next
      assign right_link = links[i+1];
      assign right_kill = kill_vec[i+1];
    end

    ptpaq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_i       (left_link),
      .right_i      (right_link),
      .right_kill_i (right_kill),
      .link_o       (links[i]),
      .kill_o       (kill_vec[i]),
      .beat_o       (beat_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // occupancy status
  always_comb begin
    holes = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH-1; i++) begin
      holes = holes | (!valid_vec[i] && valid_vec[i+1]);
    end
  end

  assign full     = valid_vec[QUEUE_DEPTH-1];
  assign tgt_ok   = ({{(32-TARGET_W){1'b0}}, req_i.target} < 32'(TARGET_COUNT));
  assign beaten   = |beat_vec;
  assign head_win = links[0].valid && !links[0].dead && !beaten;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE) && !holes;
  assign accept      = req_i.valid && req_i.ready;

  // controller: next state, cell commands, pending and output registers
  always_comb begin
    state_d        = state_q;
    pend_d         = pend_q;
    pend_target_d  = pend_target_q;
    pend_payload_d = pend_payload_q;
    out_valid_d    = out_valid_q && !rsp_o.ready;
    out_target_d   = out_target_q;
    out_payload_d  = out_payload_q;
    out_last_d     = out_last_q;

    ctrl.enq          = 1'b0;
    ctrl.cancel       = 1'b0;
    ctrl.pop          = 1'b0;
    ctrl.data.target  = req_i.target;
    ctrl.data.payload = req_i.payload;
    ctrl.data.rank    = req_i.rank;
    ctrl.head_target  = links[0].entry.target;
    ctrl.head_rank    = links[0].entry.rank;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(req_i.func))
            FUNC_ENQ:      ctrl.enq = !full && tgt_ok;
            FUNC_CANCEL:   ctrl.cancel = 1'b1;
            FUNC_DISPATCH: state_d = ST_DISPATCH;
            default:       ;
          endcase
        end
      end
      ST_DISPATCH: begin
        if (links[0].valid) begin
          // pop the head unless a winner must push out a result that cannot go
          if (!(head_win && pend_q && !out_free)) begin
            ctrl.pop = 1'b1;
            if (head_win) begin
              if (pend_q) begin
                out_valid_d   = 1'b1;
                out_target_d  = pend_target_q;
                out_payload_d = pend_payload_q;
                out_last_d    = 1'b0;
              end
              pend_d         = 1'b1;
              pend_target_d  = links[0].entry.target;
              pend_payload_d = links[0].entry.payload;
            end
          end
        end else if (pend_q) begin
          // row drained: the held winner is the last result
          if (out_free) begin
            out_valid_d   = 1'b1;
            out_target_d  = pend_target_q;
            out_payload_d = pend_payload_q;
            out_last_d    = 1'b1;
            pend_d        = 1'b0;
            state_d       = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_target_q  <= pend_target_d;
    pend_payload_q <= pend_payload_d;
    out_target_q   <= out_target_d;
    out_payload_q  <= out_payload_d;
    out_last_q     <= out_last_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.winner_target  = out_target_q;
  assign rsp_o.winner_payload = out_payload_q;
  assign rsp_o.last_of_run    = out_last_q;

`ifndef NO_ASSERTIONS
  // nothing is held back once the queue takes items again
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !pend_q)
    else $error("winner still pending while accepting items");

  // popping keeps the row packed toward the head
  a_dispatch_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISPATCH) |-> !holes)
    else $error("hole in the row during dispatch");

  // a legal enqueue adds exactly one entry
  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == FUNC_ENQ) && !full && tgt_ok)
      |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("enqueue did not add one entry");
`endif

endmodule
